### rtl/core/tsdi_pkg.sv
// ----------------------------------------------------------------------------
// tsdi_pkg
// Types, codes and helpers shared by the segment drop injector modules.
// ----------------------------------------------------------------------------
package tsdi_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int PERCENT_SCALE = 100;
	localparam int DRAW_W        = 16;
	localparam int PCT_W         = 7;
	localparam int PROD_W        = DRAW_W + PCT_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_LOSS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_START   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIENT_BUDGET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_BUDGET = 3'd4;

	localparam logic [2:0] REASON_NONE   = 3'd0;
	localparam logic [2:0] REASON_BITERR = 3'd1;
	localparam logic [2:0] REASON_RANDOM = 3'd2;
	localparam logic [2:0] REASON_BURST  = 3'd3;
	localparam logic [2:0] REASON_BUDGET = 3'd4;

	localparam logic [2:0] SEG_OTHER = 3'd4;

	typedef struct packed {
		logic        bit_error;
		logic        server_side;
		logic [2:0]  segment_type;
		logic [7:0]  dest_port;
		logic [15:0] loss_draw;
		logic [15:0] burst_draw;
	} in_t;

	typedef struct packed {
		logic       forward;
		logic [7:0] out_port;
		logic [2:0] drop_reason;
	} out_t;

	// classified frame, front to back
	typedef struct packed {
		logic [2:0] pre_reason;
		logic       server_side;
		logic       burst_hit;
		logic       budgeted;
		logic [1:0] seg_idx;
		logic [7:0] dest_port;
	} cls_t;

	// budget reload request, top to back
	typedef struct packed {
		logic        load_client;
		logic        load_server;
		logic [31:0] word;
	} budget_load_t;

	// draw/65536 < pct/100
	function automatic logic draw_below(input logic [DRAW_W-1:0] draw,
	                                    input logic [PCT_W-1:0]  pct);
		logic [PROD_W-1:0] lhs;
		logic [PROD_W-1:0] rhs;
		lhs = PROD_W'(draw) * PROD_W'(PERCENT_SCALE);
		rhs = {pct, {DRAW_W{1'b0}}};
		return lhs < rhs;
	endfunction

endpackage

### rtl/core/tsdi_front.sv
// ----------------------------------------------------------------------------
// tsdi_front
// Stateless classification: bit error, random loss, burst start draw.
// ----------------------------------------------------------------------------
module tsdi_front import tsdi_pkg::*; (
	input  in_t              frame,
	input  logic [PCT_W-1:0] loss_pct,
	input  logic [PCT_W-1:0] burst_pct,
	output cls_t             cls
);

	always_comb begin
		cls.server_side = frame.server_side;
		cls.burst_hit   = draw_below(frame.burst_draw, burst_pct);
		cls.budgeted    = (frame.segment_type < SEG_OTHER);
		cls.seg_idx     = frame.segment_type[1:0];
		cls.dest_port   = frame.dest_port;
		if (frame.bit_error) begin
			cls.pre_reason = REASON_BITERR;
		end else if (draw_below(frame.loss_draw, loss_pct)) begin
			cls.pre_reason = REASON_RANDOM;
		end else begin
			cls.pre_reason = REASON_NONE;
		end
	end

endmodule

### rtl/core/tsdi_queue.sv
// ----------------------------------------------------------------------------
// tsdi_queue
// Small register FIFO between classification and the stateful back end.
// ----------------------------------------------------------------------------
module tsdi_queue import tsdi_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_data,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output cls_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cls_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/tsdi_back.sv
// ----------------------------------------------------------------------------
// tsdi_back
// Burst and budget state; final decision into the output register.
// ----------------------------------------------------------------------------
module tsdi_back import tsdi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_not_empty,
	input  cls_t         head,
	output logic         pop,
	input  logic [7:0]   burst_len,
	input  budget_load_t bload,
	output logic         out_valid,
	input  logic         out_stall,
	output out_t         out_data
);

	logic [7:0] rem_q [8];
	logic [7:0] burst_pos_q;
	logic       out_valid_q;
	out_t       out_data_q;

	logic [2:0] idx;
	logic [7:0] rem_cur;
	logic       budget_hit;
	logic [2:0] reason;
	logic [7:0] burst_pos_nxt;

	assign pop       = q_not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign idx        = {head.server_side, head.seg_idx};
	assign rem_cur    = rem_q[idx];
	assign budget_hit = head.budgeted && (rem_cur != '0);

	always_comb begin
		reason        = REASON_NONE;
		burst_pos_nxt = burst_pos_q;
		if (head.pre_reason != REASON_NONE) begin
			reason = head.pre_reason;
		end else if (head.server_side) begin
			if (burst_pos_q != '0) begin
				if (burst_pos_q == burst_len) begin
					burst_pos_nxt = '0;
				end else begin
					burst_pos_nxt = burst_pos_q + 1'b1;
					reason        = REASON_BURST;
				end
			end else if (head.burst_hit) begin
				if (burst_len != '0) begin
					burst_pos_nxt = 8'd1;
					reason        = REASON_BURST;
				end
			end else if (budget_hit) begin
				reason = REASON_BUDGET;
			end
		end else if (budget_hit) begin
			reason = REASON_BUDGET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				rem_q[i] <= '0;
			end
			burst_pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (bload.load_client || bload.load_server) begin
				for (int k = 0; k < 4; k++) begin
					if (bload.load_client) begin
						rem_q[k] <= bload.word[8*k +: 8];
					end
					if (bload.load_server) begin
						rem_q[k + 4] <= bload.word[8*k +: 8];
					end
				end
			end else if (pop && reason == REASON_BUDGET) begin
				rem_q[idx] <= rem_cur - 1'b1;
			end
			if (pop) begin
				burst_pos_q <= burst_pos_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q.forward     <= (reason == REASON_NONE);
			out_data_q.out_port    <= (reason == REASON_NONE) ? head.dest_port : '0;
			out_data_q.drop_reason <= reason;
		end
	end

endmodule

### rtl/core/tcp_segment_drop_injector.sv
// ----------------------------------------------------------------------------
// tcp_segment_drop_injector
// Fault-injecting frame relay with random loss, drop bursts and drop budgets.
// ----------------------------------------------------------------------------
// One frame per clock sustained while the output is not stalled. A frame is
// classified in the cycle it is accepted (bit error, random loss, burst
// start draw) and written into a small queue; the back end takes one frame
// per cycle from the queue while the output is not stalled, applies the
// burst and per-type budget state and registers exactly one transaction on
// the output. Output stall can fill the queue; in_stall rises only when the
// queue is full. Writing a budget register reloads its four counters at
// once. Registers are to be written only while no frame is in flight.
module tcp_segment_drop_injector import tsdi_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [PCT_W-1:0] loss_pct_q;
	logic [PCT_W-1:0] burst_pct_q;
	logic [7:0]       burst_len_q;

	cls_t         cls;
	cls_t         head;
	logic         q_full;
	logic         q_not_empty;
	logic         pop;
	logic         push;
	budget_load_t bload;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	assign bload.load_client = cfg_we && (cfg_index == REG_CLIENT_BUDGET);
	assign bload.load_server = cfg_we && (cfg_index == REG_SERVER_BUDGET);
	assign bload.word        = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_pct_q  <= '0;
			burst_pct_q <= '0;
			burst_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANDOM_LOSS: begin
					loss_pct_q <= cfg_data[PCT_W-1:0];
				end
				REG_BURST_START: begin
					burst_pct_q <= cfg_data[PCT_W-1:0];
				end
				REG_BURST_LENGTH: begin
					burst_len_q <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	tsdi_front u_front (
		.frame     (in_data),
		.loss_pct  (loss_pct_q),
		.burst_pct (burst_pct_q),
		.cls       (cls)
	);

	tsdi_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	tsdi_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.burst_len   (burst_len_q),
		.bload       (bload),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tcp_segment_drop_injector. Frames go in through a
// valid/stall channel with random idle cycles, results come back under random
// output stall. A local model of the drop rules (bit error, random loss,
// server burst, per-type budgets) predicts each result in order, and every
// output transaction is compared against it field by field.
// ----------------------------------------------------------------------------
module testbench;
	import tsdi_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_t                   in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                  quiet = 1'b0;
	int                    mismatches = 0;
	out_t                  pending_results[$];

	// model state
	logic [6:0]            loss_pct = '0;
	logic [6:0]            burst_pct = '0;
	logic [7:0]            burst_len = '0;
	logic [7:0]            burst_pos = '0;
	logic [7:0]            drops_left[0:7] = '{default: '0};

	tcp_segment_drop_injector uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < 18);
	end

	function automatic logic frac_below(input logic [15:0] draw, input logic [6:0] pct);
		return int'(draw) * 100 < int'(pct) * 65536;
	endfunction

	function automatic out_t predict_frame(input in_t f);
		out_t       r;
		logic [2:0] why;
		int         slot;
		why = REASON_NONE;
		if (f.bit_error) begin
			why = REASON_BITERR;
		end else if (frac_below(f.loss_draw, loss_pct)) begin
			why = REASON_RANDOM;
		end else if (f.server_side && burst_pos != 8'd0) begin
			if (burst_pos == burst_len) begin
				burst_pos = 8'd0;
			end else begin
				burst_pos = burst_pos + 8'd1;
				why = REASON_BURST;
			end
		end else if (f.server_side && frac_below(f.burst_draw, burst_pct)) begin
			if (burst_len != 8'd0) begin
				burst_pos = 8'd1;
				why = REASON_BURST;
			end
		end else if (f.segment_type < SEG_OTHER) begin
			slot = int'({f.server_side, f.segment_type[1:0]});
			if (drops_left[slot] != 8'd0) begin
				drops_left[slot] = drops_left[slot] - 8'd1;
				why = REASON_BUDGET;
			end
		end
		r.forward = (why == REASON_NONE);
		r.out_port = r.forward ? f.dest_port : 8'd0;
		r.drop_reason = why;
		return r;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
	                                  input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_RANDOM_LOSS: begin
				loss_pct = val[6:0];
			end
			REG_BURST_START: begin
				burst_pct = val[6:0];
			end
			REG_BURST_LENGTH: begin
				burst_len = val[7:0];
			end
			REG_CLIENT_BUDGET: begin
				for (int k = 0; k < 4; k++) drops_left[k] = val[8*k +: 8];
			end
			REG_SERVER_BUDGET: begin
				for (int k = 0; k < 4; k++) drops_left[4 + k] = val[8*k +: 8];
			end
			default: begin
			end
		endcase
	endfunction

	// checker: compare before predicting, a result never belongs to a same-edge input
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result transaction: %p", out_data);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (out_data.forward !== want.forward) begin
						$error("forward: expected %0d, got %0d", want.forward, out_data.forward);
						mismatches++;
					end
					if (out_data.out_port !== want.out_port) begin
						$error("out_port: expected %0d, got %0d", want.out_port,
						       out_data.out_port);
						mismatches++;
					end
					if (out_data.drop_reason !== want.drop_reason) begin
						$error("drop_reason: expected %0d, got %0d", want.drop_reason,
						       out_data.drop_reason);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) pending_results.push_back(predict_frame(in_data));
		end
	end

	function automatic in_t mk_frame(input logic err, input logic server,
	                                 input logic [2:0] seg, input logic [7:0] port,
	                                 input logic [15:0] loss, input logic [15:0] burst);
		in_t f;
		f.bit_error = err;
		f.server_side = server;
		f.segment_type = seg;
		f.dest_port = port;
		f.loss_draw = loss;
		f.burst_draw = burst;
		return f;
	endfunction

	function automatic in_t rand_frame(input logic server_only);
		in_t f;
		f.bit_error = ($urandom_range(0, 11) == 0);
		f.server_side = server_only ? 1'b1 : 1'($urandom_range(0, 1));
		f.segment_type = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 3))
		                                               : 3'($urandom_range(4, 7));
		f.dest_port = 8'($urandom);
		f.loss_draw = 16'($urandom);
		f.burst_draw = 16'($urandom);
		return f;
	endfunction

	// returns at the accepting edge; the next caller moves to the falling edge
	task automatic send_frame(input in_t f);
		@(negedge clk);
		if (!quiet) begin
			while ($urandom_range(0, 99) < 18) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		end
		in_valid = 1'b1;
		in_data = f;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wait_drained();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		apply_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_defaults();
		send_frame(mk_frame(1'b0, 1'b0, 3'd0, 8'd0, 16'h0000, 16'h0000));
		send_frame(mk_frame(1'b0, 1'b1, 3'd3, 8'd255, 16'hFFFF, 16'hFFFF));
		send_frame(mk_frame(1'b0, 1'b0, 3'd7, 8'd17, 16'h0000, 16'hFFFF));
		send_frame(mk_frame(1'b1, 1'b0, 3'd1, 8'd255, 16'hFFFF, 16'h0000));
		send_frame(mk_frame(1'b1, 1'b1, 3'd2, 8'd0, 16'h0000, 16'h0000));
		send_frame(mk_frame(1'b0, 1'b1, SEG_OTHER, 8'd128, 16'h8000, 16'h8000));
	endtask

	task automatic test_loss_threshold();
		set_reg(REG_RANDOM_LOSS, 32'd50);
		send_frame(mk_frame(1'b0, 1'b0, 3'd2, 8'd9, 16'd32767, 16'h0000));
		send_frame(mk_frame(1'b0, 1'b1, 3'd2, 8'd9, 16'd32768, 16'h0000));
		set_reg(REG_RANDOM_LOSS, 32'd100);
		send_frame(mk_frame(1'b0, 1'b0, 3'd0, 8'd1, 16'hFFFF, 16'h0000));
		// upper data bits are masked off, leaving a percent above 100
		set_reg(REG_RANDOM_LOSS, 32'hFFFF_FFFF);
		send_frame(mk_frame(1'b0, 1'b1, 3'd0, 8'd2, 16'hFFFF, 16'hFFFF));
		set_reg(REG_RANDOM_LOSS, 32'd0);
	endtask

	task automatic test_budgets();
		set_reg(REG_CLIENT_BUDGET, 32'h0101_0002);
		repeat (3) send_frame(mk_frame(1'b0, 1'b0, 3'd0, 8'd33, 16'h1234, 16'h0000));
		repeat (2) send_frame(mk_frame(1'b0, 1'b0, 3'd3, 8'd44, 16'h4321, 16'h0000));
		send_frame(mk_frame(1'b0, 1'b0, SEG_OTHER, 8'd55, 16'hFFFF, 16'h0000));
		set_reg(REG_SERVER_BUDGET, 32'hFFFF_FFFF);
		send_frame(mk_frame(1'b0, 1'b1, 3'd1, 8'd66, 16'hFFFF, 16'hFFFF));
		set_reg(REG_SERVER_BUDGET, 32'h0000_0000);
		send_frame(mk_frame(1'b0, 1'b1, 3'd1, 8'd77, 16'hFFFF, 16'hFFFF));
	endtask

	task automatic test_burst();
		set_reg(REG_SERVER_BUDGET, 32'h0505_0505);
		set_reg(REG_BURST_START, 32'd100);
		set_reg(REG_BURST_LENGTH, 32'd2);
		repeat (4) send_frame(mk_frame(1'b0, 1'b1, 3'd1, 8'd88, 16'hFFFF, 16'hFFFF));
		send_frame(mk_frame(1'b0, 1'b0, 3'd1, 8'd99, 16'hFFFF, 16'h0000));
		repeat (2) send_frame(mk_frame(1'b0, 1'b1, 3'd2, 8'd111, 16'hFFFF, 16'h0000));
		set_reg(REG_BURST_LENGTH, 32'd0);
		send_frame(mk_frame(1'b0, 1'b1, 3'd0, 8'd222, 16'hFFFF, 16'h0000));
		set_reg(REG_BURST_START, 32'd0);
	endtask

	// length lowered mid-burst: position runs on and wraps through zero
	task automatic test_burst_wrap();
		set_reg(REG_BURST_START, 32'd100);
		set_reg(REG_BURST_LENGTH, 32'd3);
		repeat (2) send_frame(rand_frame(1'b1));
		set_reg(REG_BURST_LENGTH, 32'd1);
		repeat (260) send_frame(rand_frame(1'b1));
		set_reg(REG_BURST_START, 32'd0);
		set_reg(REG_BURST_LENGTH, 32'd0);
	endtask

	task automatic test_random();
		logic [6:0]  pct;
		logic [7:0]  blen;
		logic [31:0] budget;
		for (int k = int'(REG_SERVER_BUDGET) + 1; k < (1 << CFG_IDX_W); k++)
			set_reg(CFG_IDX_W'(k), $urandom);
		for (int ph = 0; ph < 6; ph++) begin
			case ($urandom_range(0, 5))
				0, 1: pct = 7'd0;
				2, 3: pct = 7'($urandom_range(1, 20));
				4: pct = 7'($urandom_range(20, 100));
				default: pct = 7'($urandom_range(101, 127));
			endcase
			set_reg(REG_RANDOM_LOSS, ($urandom & ~32'h7F) | 32'(pct));
			pct = 7'($urandom_range(0, 40));
			set_reg(REG_BURST_START, ($urandom & ~32'h7F) | 32'(pct));
			blen = (ph == 5) ? 8'd255 : 8'($urandom_range(0, 12));
			set_reg(REG_BURST_LENGTH, ($urandom & ~32'hFF) | 32'(blen));
			for (int b = 0; b < 4; b++) budget[8*b +: 8] = 8'($urandom_range(0, 10));
			set_reg(REG_CLIENT_BUDGET, (ph == 4) ? 32'hFFFF_FFFF : budget);
			for (int b = 0; b < 4; b++) budget[8*b +: 8] = 8'($urandom_range(0, 10));
			set_reg(REG_SERVER_BUDGET, budget);
			quiet = (ph == 2);
			repeat (200) send_frame(rand_frame(1'b0));
			quiet = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_defaults();
		test_loss_threshold();
		test_budgets();
		test_burst();
		test_burst_wrap();
		test_random();

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
